@@ rtl/metu_pkg.sv @@
// Shared types and constants of the multichannel envelope tracker
`timescale 1ns / 1ps
package metu_pkg;

   localparam int DEF_CHANNELS    = 64;
   localparam int DEF_VALUE_WIDTH = 32;
   localparam int DEF_TIME_WIDTH  = 32;
   localparam int QUEUE_DEPTH     = 2;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 7;
   localparam int ACT_W       = 7;
   localparam logic [ACT_W-1:0] ACT_RESET = 7'd64;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEEP_TIMES = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE     = 1'd1;

   localparam logic [1:0] OP_SAMPLE  = 2'd0;
   localparam logic [1:0] OP_READ    = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   localparam logic [1:0] ROW_ABSMAX = 2'd0;
   localparam logic [1:0] ROW_MAX    = 2'd1;
   localparam logic [1:0] ROW_MIN    = 2'd2;

   typedef enum logic [1:0] {
      KIND_SAMPLE,
      KIND_READ,
      KIND_RESTART
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic       ok;
      logic [1:0] row_sel;
      logic       rearm;
   } ctrl_type;

endpackage

@@ rtl/metu_ram.sv @@
// Generic single write port RAM with registered read
`timescale 1ns / 1ps
module metu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/metu_queue.sv @@
// Short FIFO between the classifying front and the update back end
`timescale 1ns / 1ps
module metu_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = metu_pkg::QUEUE_DEPTH,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   output logic             valid,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == (AW+1)'(DEPTH));
   assign valid   = (count_ff != '0);
   assign do_push = push && !full;
   assign do_pop  = pop && valid;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ rtl/metu_front.sv @@
// Front end: configuration registers, beat classification and magnitude
`timescale 1ns / 1ps
module metu_front #(
   parameter int CHANNELS    = metu_pkg::DEF_CHANNELS,
   parameter int VALUE_WIDTH = metu_pkg::DEF_VALUE_WIDTH,
   parameter int TIME_WIDTH  = metu_pkg::DEF_TIME_WIDTH,
   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wen,
   input  logic [metu_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [metu_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [1:0]                        op,
   input  logic [CH_W-1:0]                   channel,
   input  logic [VALUE_WIDTH-1:0]            sample_value,
   input  logic [TIME_WIDTH-1:0]             sample_time,
   input  logic [1:0]                        row_select,
   input  logic                              clear_after_read,
   output logic                              keep_times,
   output logic                              q_push,
   input  logic                              q_full,
   output metu_pkg::ctrl_type                q_ctrl,
   output logic [CH_W-1:0]                   q_ch,
   output logic [VALUE_WIDTH-1:0]            q_value,
   output logic [VALUE_WIDTH-2:0]            q_mag,
   output logic [TIME_WIDTH-1:0]             q_time
);
   import metu_pkg::*;

   localparam int CMP_W = ((CH_W > ACT_W) ? CH_W : ACT_W) + 1;
   localparam logic [VALUE_WIDTH-1:0] MOST_NEG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   logic             keep_times_ff;
   logic [ACT_W-1:0] active_ff;
   logic             in_use, keep;
   logic [VALUE_WIDTH-1:0] negated;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_times_ff <= 1'b0;
         active_ff     <= ACT_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_KEEP_TIMES: keep_times_ff <= csr_wdata[0];
            CSR_ACTIVE:     active_ff     <= csr_wdata[ACT_W-1:0];
            default: ;
         endcase
      end
   end

   assign keep_times = keep_times_ff;

   assign in_use = (CMP_W'(channel) < CMP_W'(CHANNELS)) &&
                   (CMP_W'(channel) < CMP_W'(active_ff));

   always_comb begin
      q_ctrl.kind    = KIND_SAMPLE;
      q_ctrl.ok      = in_use;
      q_ctrl.row_sel = row_select;
      q_ctrl.rearm   = clear_after_read && in_use;
      keep           = 1'b0;
      case (op)
         OP_SAMPLE: begin
            keep = in_use;
         end
         OP_READ: begin
            q_ctrl.kind = KIND_READ;
            keep        = 1'b1;
         end
         OP_RESTART: begin
            q_ctrl.kind = KIND_RESTART;
            keep        = 1'b1;
         end
         default: ;
      endcase
   end

   // saturate the most negative value at the largest positive magnitude
   assign negated = ~sample_value + 1'b1;
   always_comb begin
      if (!sample_value[VALUE_WIDTH-1]) begin
         q_mag = sample_value[VALUE_WIDTH-2:0];
      end else if (sample_value == MOST_NEG) begin
         q_mag = '1;
      end else begin
         q_mag = negated[VALUE_WIDTH-2:0];
      end
   end

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full && keep;
   assign q_ch       = channel;
   assign q_value    = sample_value;
   assign q_time     = sample_time;

endmodule

@@ rtl/metu_back.sv @@
// Back end: per-channel row read-modify-write with forwarding and result register
`timescale 1ns / 1ps
module metu_back #(
   parameter int CHANNELS    = metu_pkg::DEF_CHANNELS,
   parameter int VALUE_WIDTH = metu_pkg::DEF_VALUE_WIDTH,
   parameter int TIME_WIDTH  = metu_pkg::DEF_TIME_WIDTH,
   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   keep_times,
   input  logic                   q_valid,
   output logic                   q_pop,
   input  metu_pkg::ctrl_type     q_ctrl,
   input  logic [CH_W-1:0]        q_ch,
   input  logic [VALUE_WIDTH-1:0] q_value,
   input  logic [VALUE_WIDTH-2:0] q_mag,
   input  logic [TIME_WIDTH-1:0]  q_time,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [VALUE_WIDTH-1:0] rsp_value,
   output logic [TIME_WIDTH-1:0]  rsp_time,
   output logic                   rsp_ok
);
   import metu_pkg::*;

   localparam int ROW_W = 3*VALUE_WIDTH - 1 + 3*TIME_WIDTH;

   logic                   s1_valid_ff;
   ctrl_type               s1_ctrl_ff;
   logic [CH_W-1:0]        s1_ch_ff;
   logic [VALUE_WIDTH-1:0] s1_value_ff;
   logic [VALUE_WIDTH-2:0] s1_mag_ff;
   logic [TIME_WIDTH-1:0]  s1_time_ff;
   logic                   hit_ff, hit_in;
   logic [ROW_W-1:0]       byp_row_ff;

   logic [CHANNELS-1:0] armed_ff, armed_in, cleared_ff, cleared_in;
   logic [CHANNELS-1:0] tv_min_ff, tv_min_in, tv_max_ff, tv_max_in, tv_abs_ff, tv_abs_in;

   logic                   rsp_valid_ff;
   logic [VALUE_WIDTH-1:0] rsp_value_ff, rd_value;
   logic [TIME_WIDTH-1:0]  rsp_time_ff, rd_time;
   logic                   rsp_ok_ff;

   logic             s1_is_read, s1_wr, s1_fire;
   logic [ROW_W-1:0] ram_rd_data, old_row, new_row;

   logic [VALUE_WIDTH-1:0] o_min, o_max, n_min, n_max;
   logic [VALUE_WIDTH-2:0] o_abs, n_abs;
   logic [TIME_WIDTH-1:0]  o_tmin, o_tmax, o_tabs, n_tmin, n_tmax, n_tabs;
   logic armed, cleared, lo, hi, ab, wt_min, wt_max, wt_abs;

   assign s1_is_read = (s1_ctrl_ff.kind == KIND_READ);
   assign s1_wr      = (s1_ctrl_ff.kind == KIND_SAMPLE) && s1_ctrl_ff.ok;
   assign s1_fire    = s1_valid_ff && (!s1_is_read || !rsp_valid_ff || rsp_tready);
   assign q_pop      = q_valid && (!s1_valid_ff || s1_fire);
   assign hit_in     = s1_fire && s1_wr && (q_ch == s1_ch_ff);

   metu_ram #(
      .WIDTH (ROW_W),
      .DEPTH (CHANNELS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (s1_fire && s1_wr),
      .wr_addr (s1_ch_ff),
      .wr_data (new_row),
      .rd_en   (q_pop),
      .rd_addr (q_ch),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         hit_ff      <= 1'b0;
      end else begin
         if (q_pop) begin
            s1_valid_ff <= 1'b1;
            hit_ff      <= hit_in;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_ctrl_ff  <= q_ctrl;
         s1_ch_ff    <= q_ch;
         s1_value_ff <= q_value;
         s1_mag_ff   <= q_mag;
         s1_time_ff  <= q_time;
      end
      if (s1_fire && s1_wr) begin
         byp_row_ff <= new_row;
      end
   end

   // forward the row written in the cycle of our read
   assign old_row = hit_ff ? byp_row_ff : ram_rd_data;
   assign {o_tabs, o_tmax, o_tmin, o_abs, o_max, o_min} = old_row;

   assign armed   = armed_ff[s1_ch_ff];
   assign cleared = cleared_ff[s1_ch_ff];
   assign lo = $signed(s1_value_ff) < $signed(o_min);
   assign hi = !lo && ($signed(o_max) < $signed(s1_value_ff));
   assign ab = (lo || hi) && (o_abs < s1_mag_ff);

   always_comb begin
      n_min = o_min;
      n_max = o_max;
      n_abs = o_abs;
      if (armed) begin
         n_min = s1_value_ff;
         n_max = s1_value_ff;
         n_abs = s1_mag_ff;
      end else begin
         if (lo) begin
            n_min = s1_value_ff;
         end
         if (hi) begin
            n_max = s1_value_ff;
         end
         if (ab) begin
            n_abs = s1_mag_ff;
         end
      end
   end

   assign wt_min = keep_times && (armed || lo);
   assign wt_max = keep_times && (armed || hi);
   assign wt_abs = keep_times && (armed || ab);
   assign n_tmin = wt_min ? s1_time_ff : o_tmin;
   assign n_tmax = wt_max ? s1_time_ff : o_tmax;
   assign n_tabs = wt_abs ? s1_time_ff : o_tabs;
   assign new_row = {n_tabs, n_tmax, n_tmin, n_abs, n_max, n_min};

   always_comb begin
      rd_value = '0;
      rd_time  = '0;
      if (s1_ctrl_ff.ok && !cleared) begin
         case (s1_ctrl_ff.row_sel)
            ROW_ABSMAX: begin
               rd_value = {1'b0, o_abs};
               rd_time  = tv_abs_ff[s1_ch_ff] ? o_tabs : '0;
            end
            ROW_MAX: begin
               rd_value = o_max;
               rd_time  = tv_max_ff[s1_ch_ff] ? o_tmax : '0;
            end
            ROW_MIN: begin
               rd_value = o_min;
               rd_time  = tv_min_ff[s1_ch_ff] ? o_tmin : '0;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      armed_in   = armed_ff;
      cleared_in = cleared_ff;
      tv_min_in  = tv_min_ff;
      tv_max_in  = tv_max_ff;
      tv_abs_in  = tv_abs_ff;
      if (s1_fire) begin
         case (s1_ctrl_ff.kind)
            KIND_SAMPLE: begin
               if (s1_ctrl_ff.ok) begin
                  armed_in[s1_ch_ff]   = 1'b0;
                  cleared_in[s1_ch_ff] = 1'b0;
                  if (wt_min) begin
                     tv_min_in[s1_ch_ff] = 1'b1;
                  end
                  if (wt_max) begin
                     tv_max_in[s1_ch_ff] = 1'b1;
                  end
                  if (wt_abs) begin
                     tv_abs_in[s1_ch_ff] = 1'b1;
                  end
               end
            end
            KIND_READ: begin
               if (s1_ctrl_ff.rearm) begin
                  armed_in = '1;
               end
            end
            KIND_RESTART: begin
               armed_in   = '1;
               cleared_in = '1;
               tv_min_in  = '0;
               tv_max_in  = '0;
               tv_abs_in  = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff   <= '1;
         cleared_ff <= '1;
         tv_min_ff  <= '0;
         tv_max_ff  <= '0;
         tv_abs_ff  <= '0;
      end else begin
         armed_ff   <= armed_in;
         cleared_ff <= cleared_in;
         tv_min_ff  <= tv_min_in;
         tv_max_ff  <= tv_max_in;
         tv_abs_ff  <= tv_abs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire && s1_is_read) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_is_read) begin
         rsp_value_ff <= rd_value;
         rsp_time_ff  <= rd_time;
         rsp_ok_ff    <= s1_ctrl_ff.ok;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_time   = rsp_time_ff;
   assign rsp_ok     = rsp_ok_ff;

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      s1_fire && (s1_ctrl_ff.kind == KIND_RESTART) |=>
         (&armed_ff) && (&cleared_ff) && (tv_min_ff == '0) && (tv_abs_ff == '0))
      else $error("restart did not re-arm and clear every channel");

   a_sample_disarms: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_wr |=> !armed_ff[$past(s1_ch_ff)] && !cleared_ff[$past(s1_ch_ff)])
      else $error("sample left its channel armed or cleared");

   a_forward_source: assert property (@(posedge clock) disable iff (reset)
      $rose(s1_valid_ff) && hit_ff |-> $past(s1_fire && s1_wr))
      else $error("forwarded row without a preceding write");

   a_idle_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> (rsp_value_ff == '0) && (rsp_time_ff == '0))
      else $error("inactive channel read returned non-zero data");

endmodule

@@ rtl/multichannel_envelope_tracker_unit.sv @@
// Top level of the multichannel min / max / peak-magnitude envelope tracker
`timescale 1ns / 1ps
// Takes one beat per clock while the queue has room: a sample, read or restart
// beat is classified and queued by the front end, then the back end reads the
// channel's row from a single row RAM, updates it and, for a sample, writes it
// back in the following cycle, forwarding the row just written when consecutive
// beats hit the same channel. The sustained rate is one beat per cycle unless a
// read result is held by rsp_tready, set by the one read and at most one write
// of the row RAM per beat; a read result passes through the queue, the stage-1
// registers and the response register to rsp. Restart takes effect through
// per-channel flags, with no clearing pass over the RAM. Samples for channels at
// or above active_channels are dropped; reads of them give read_ok low, zero data.
module multichannel_envelope_tracker_unit #(
   parameter int CHANNELS    = metu_pkg::DEF_CHANNELS,
   parameter int VALUE_WIDTH = metu_pkg::DEF_VALUE_WIDTH,
   parameter int TIME_WIDTH  = metu_pkg::DEF_TIME_WIDTH,
   localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
   localparam int REQ_DATA_W = ((CH_W + VALUE_WIDTH + TIME_WIDTH + 3 + 7) / 8) * 8,
   localparam int RSP_DATA_W = ((VALUE_WIDTH + TIME_WIDTH + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wen,
   input  logic [metu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [metu_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // channel, sample_value, sample_time, row_select, clear_after_read, zero fill
   input  logic [REQ_DATA_W-1:0]            req_tdata,
   // op
   input  logic [1:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // read_value, read_time, zero fill
   output logic [RSP_DATA_W-1:0]            rsp_tdata,
   // read_ok
   output logic                             rsp_tuser
);
   import metu_pkg::*;

   localparam int VAL_LO  = CH_W;
   localparam int TIME_LO = VAL_LO + VALUE_WIDTH;
   localparam int SEL_LO  = TIME_LO + TIME_WIDTH;
   localparam int CLR_BIT = SEL_LO + 2;
   localparam int ENTRY_W = $bits(ctrl_type) + CH_W + 2*VALUE_WIDTH - 1 + TIME_WIDTH;

   logic                   keep_times;
   logic                   q_push, q_full, q_valid, q_pop;
   ctrl_type               f_ctrl, b_ctrl;
   logic [CH_W-1:0]        f_ch, b_ch;
   logic [VALUE_WIDTH-1:0] f_value, b_value;
   logic [VALUE_WIDTH-2:0] f_mag, b_mag;
   logic [TIME_WIDTH-1:0]  f_time, b_time;
   logic [ENTRY_W-1:0]     q_wr_data, q_rd_data;
   logic [VALUE_WIDTH-1:0] rsp_value;
   logic [TIME_WIDTH-1:0]  rsp_time;

   metu_front #(
      .CHANNELS    (CHANNELS),
      .VALUE_WIDTH (VALUE_WIDTH),
      .TIME_WIDTH  (TIME_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .op               (req_tuser),
      .channel          (req_tdata[CH_W-1:0]),
      .sample_value     (req_tdata[TIME_LO-1:VAL_LO]),
      .sample_time      (req_tdata[SEL_LO-1:TIME_LO]),
      .row_select       (req_tdata[CLR_BIT-1:SEL_LO]),
      .clear_after_read (req_tdata[CLR_BIT]),
      .keep_times       (keep_times),
      .q_push           (q_push),
      .q_full           (q_full),
      .q_ctrl           (f_ctrl),
      .q_ch             (f_ch),
      .q_value          (f_value),
      .q_mag            (f_mag),
      .q_time           (f_time)
   );

   assign q_wr_data = {f_ctrl, f_ch, f_value, f_mag, f_time};

   metu_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_data),
      .full    (q_full),
      .valid   (q_valid),
      .pop     (q_pop),
      .rd_data (q_rd_data)
   );

   assign {b_ctrl, b_ch, b_value, b_mag, b_time} = q_rd_data;

   metu_back #(
      .CHANNELS    (CHANNELS),
      .VALUE_WIDTH (VALUE_WIDTH),
      .TIME_WIDTH  (TIME_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .keep_times (keep_times),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_ctrl     (b_ctrl),
      .q_ch       (b_ch),
      .q_value    (b_value),
      .q_mag      (b_mag),
      .q_time     (b_time),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_value  (rsp_value),
      .rsp_time   (rsp_time),
      .rsp_ok     (rsp_tuser)
   );

   assign rsp_tdata = RSP_DATA_W'({rsp_time, rsp_value});

endmodule
